[sv/lmts_pkg.sv]
// Shared types, timing constants and register indexes of the LCD mode timing sequencer.
package lmts_pkg;

   localparam int unsigned ACC_W = 10;
   localparam int unsigned LINE_W = 8;
   localparam int unsigned CYC_W = 8;
   localparam int unsigned CSR_DATA_W = 8;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [ACC_W-1:0] HBLANK_LEN = 10'd204;
   localparam logic [ACC_W-1:0] VBLANK_LINE_LEN = 10'd456;
   localparam logic [ACC_W-1:0] OAM_SCAN_LEN = 10'd80;
   localparam logic [ACC_W-1:0] TRANSFER_LEN = 10'd172;
   localparam logic [ACC_W-1:0] ACC_MAX = 10'd1023;
   localparam logic [LINE_W-1:0] VISIBLE_LINES = 8'd144;
   localparam logic [LINE_W-1:0] LAST_LINE = 8'd153;

   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_COMPARE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STAT_IRQ_ENABLES = 2'd2;

   localparam int unsigned EN_COINCIDENCE = 3;

   typedef enum logic [1:0] {
      MODE_H_BLANK   = 2'd0,
      MODE_V_BLANK   = 2'd1,
      MODE_OBJ_SCAN  = 2'd2,
      MODE_TRANSFER  = 2'd3
   } mode_type;

   typedef struct packed {
      logic              display_enable;
      logic [LINE_W-1:0] line_compare;
      logic [3:0]        stat_irq_enables;
   } cfg_type;

   typedef struct packed {
      mode_type          mode;
      logic [LINE_W-1:0] line;
      logic [ACC_W-1:0]  acc;
      logic              coincidence;
   } state_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [LINE_W-1:0] line;
      logic              coincidence;
      logic              vblank_irq;
      logic              stat_irq;
      logic              line_rendered;
   } result_type;

endpackage

[sv/lmts_req_if.sv]
// Input channel: one word of elapsed machine cycles.
interface lmts_req_if;
   logic                         valid;
   logic                         ready;
   logic [lmts_pkg::CYC_W-1:0]   elapsed_cycles;

   modport source (output valid, output elapsed_cycles, input ready);
   modport sink (input valid, input elapsed_cycles, output ready);
endinterface

[sv/lmts_rsp_if.sv]
// Result channel: mode, line and request flags for one step.
interface lmts_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    mode;
   logic [lmts_pkg::LINE_W-1:0]   line;
   logic                          coincidence;
   logic                          vblank_irq;
   logic                          stat_irq;
   logic                          line_rendered;

   modport source (output valid, output mode, output line, output coincidence,
                   output vblank_irq, output stat_irq, output line_rendered, input ready);
   modport sink (input valid, input mode, input line, input coincidence,
                 input vblank_irq, input stat_irq, input line_rendered, output ready);
endinterface

[sv/lcd_mode_timing_sequencer_top.sv]
// Top level of the LCD mode timing sequencer: input register, step logic, result register.
//
//   channel | direction | handshake      | payload
//   --------+-----------+----------------+-------------------------------------------
//   req_if  | in        | valid/ready    | elapsed_cycles[7:0]
//   rsp_if  | out       | valid/ready    | mode, line, coincidence, irqs, line_rendered
//   csr_*   | in        | csr_wr_en only | csr_index[1:0], csr_wdata[7:0]
//
// A word sits in the input register while the step logic works on it; the result register
// and the timing state then load together, and the result word becomes valid. One word
// is accepted per cycle while the result register is free or being drained.
// A stalled result holds the result register; the input register then holds too and
// ready drops only when both are full. Synchronous reset clears the timing state to
// hblank, line 0, empty accumulator, coincidence set; display is enabled.
module lcd_mode_timing_sequencer_top (
   input  logic                                clock,
   input  logic                                reset,
   lmts_req_if.sink                            req_if,
   lmts_rsp_if.source                          rsp_if,
   input  logic                                csr_wr_en,
   input  logic [lmts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lmts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   lmts_pkg::cfg_type              cfg;
   lmts_pkg::state_type            state_ff;
   lmts_pkg::state_type            state_in;
   lmts_pkg::result_type           res_ff;
   lmts_pkg::result_type           res_in;
   logic                           in_valid_ff;
   logic [lmts_pkg::CYC_W-1:0]     in_cycles_ff;
   logic                           out_valid_ff;
   logic                           out_load;
   logic                           in_load;

   lmts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lmts_step u_step (
      .cfg            (cfg),
      .cur            (state_ff),
      .elapsed_cycles (in_cycles_ff),
      .nxt            (state_in),
      .res            (res_in)
   );

   // advance the step when the result register is free or being drained
   assign out_load = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || out_load;
   assign in_load = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff.mode <= lmts_pkg::MODE_H_BLANK;
         state_ff.line <= '0;
         state_ff.acc <= '0;
         state_ff.coincidence <= 1'b1;
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
            state_ff <= state_in;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_cycles_ff <= req_if.elapsed_cycles;
      end
      if (out_load) begin
         res_ff <= res_in;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.mode = res_ff.mode;
   assign rsp_if.line = res_ff.line;
   assign rsp_if.coincidence = res_ff.coincidence;
   assign rsp_if.vblank_irq = res_ff.vblank_irq;
   assign rsp_if.stat_irq = res_ff.stat_irq;
   assign rsp_if.line_rendered = res_ff.line_rendered;

   a_line_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.line <= lmts_pkg::LAST_LINE)
      else $error("scan line beyond last line");

   a_frozen_when_disabled: assert property (@(posedge clock) disable iff (reset)
      out_load && !cfg.display_enable |=> state_ff == $past(state_ff))
      else $error("timing state moved while display disabled");

   a_vblank_entry: assert property (@(posedge clock) disable iff (reset)
      out_load && res_in.vblank_irq |=>
         state_ff.mode == lmts_pkg::MODE_V_BLANK && state_ff.line == lmts_pkg::VISIBLE_LINES)
      else $error("vblank request without entering vblank at the first blank line");

   a_rendered_to_hblank: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && res_ff.line_rendered |-> res_ff.mode == lmts_pkg::MODE_H_BLANK)
      else $error("line rendered pulse outside hblank entry");

endmodule

[sv/lmts_csr.sv]
// Configuration registers of the LCD mode timing sequencer.
module lmts_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [lmts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lmts_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output lmts_pkg::cfg_type                   cfg
);

   lmts_pkg::cfg_type cfg_ff;
   lmts_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lmts_pkg::CSR_DISPLAY_ENABLE:   cfg_in.display_enable = csr_wdata[0];
            lmts_pkg::CSR_LINE_COMPARE:     cfg_in.line_compare = csr_wdata;
            lmts_pkg::CSR_STAT_IRQ_ENABLES: cfg_in.stat_irq_enables = csr_wdata[3:0];
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_enable <= 1'b1;
         cfg_ff.line_compare <= '0;
         cfg_ff.stat_irq_enables <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/lmts_step.sv]
// One sequencer step: accumulate cycles, take at most one mode transition, raise requests.
module lmts_step (
   input  lmts_pkg::cfg_type                 cfg,
   input  lmts_pkg::state_type               cur,
   input  logic [lmts_pkg::CYC_W-1:0]        elapsed_cycles,
   output lmts_pkg::state_type               nxt,
   output lmts_pkg::result_type              res
);

   logic [lmts_pkg::ACC_W:0]      sum;
   logic [lmts_pkg::ACC_W-1:0]    acc_sat;
   logic [lmts_pkg::ACC_W-1:0]    dur;
   logic [lmts_pkg::LINE_W-1:0]   line_inc;
   logic                          hit;
   logic                          entry;
   logic                          rendered;
   logic                          coin;
   logic                          stat;
   logic                          vblank;

   always_comb begin
      sum = {1'b0, cur.acc} + {{(lmts_pkg::ACC_W + 1 - lmts_pkg::CYC_W){1'b0}}, elapsed_cycles};
      acc_sat = sum[lmts_pkg::ACC_W] ? lmts_pkg::ACC_MAX : sum[lmts_pkg::ACC_W-1:0];
      line_inc = cur.line + 8'd1;

      unique case (cur.mode)
         lmts_pkg::MODE_H_BLANK:  dur = lmts_pkg::HBLANK_LEN;
         lmts_pkg::MODE_V_BLANK:  dur = lmts_pkg::VBLANK_LINE_LEN;
         lmts_pkg::MODE_OBJ_SCAN: dur = lmts_pkg::OAM_SCAN_LEN;
         default:                 dur = lmts_pkg::TRANSFER_LEN;
      endcase
      hit = (acc_sat >= dur);

      nxt = cur;
      entry = 1'b0;
      rendered = 1'b0;
      coin = 1'b0;
      stat = 1'b0;
      vblank = 1'b0;

      if (cfg.display_enable) begin
         nxt.acc = acc_sat;
         if (hit) begin
            nxt.acc = acc_sat - dur;
            case (cur.mode)
               lmts_pkg::MODE_H_BLANK: begin
                  nxt.line = line_inc;
                  nxt.mode = (line_inc == lmts_pkg::VISIBLE_LINES) ?
                             lmts_pkg::MODE_V_BLANK : lmts_pkg::MODE_OBJ_SCAN;
                  entry = 1'b1;
               end
               lmts_pkg::MODE_V_BLANK: begin
                  if (cur.line >= lmts_pkg::LAST_LINE) begin
                     nxt.line = '0;
                     nxt.mode = lmts_pkg::MODE_OBJ_SCAN;
                     entry = 1'b1;
                  end else begin
                     nxt.line = line_inc;
                  end
               end
               lmts_pkg::MODE_OBJ_SCAN: begin
                  nxt.mode = lmts_pkg::MODE_TRANSFER;
                  entry = 1'b1;
               end
               default: begin
                  nxt.mode = lmts_pkg::MODE_H_BLANK;
                  entry = 1'b1;
                  rendered = 1'b1;
               end
            endcase
            // every transition re-evaluates coincidence against the new line
            coin = (nxt.line == cfg.line_compare);
            nxt.coincidence = coin;
            stat = (coin && cfg.stat_irq_enables[lmts_pkg::EN_COINCIDENCE]) ||
                   (entry && (nxt.mode != lmts_pkg::MODE_TRANSFER) &&
                    cfg.stat_irq_enables[nxt.mode]);
            vblank = entry && (nxt.mode == lmts_pkg::MODE_V_BLANK);
         end
      end

      res.mode = nxt.mode;
      res.line = nxt.line;
      res.coincidence = nxt.coincidence;
      res.vblank_irq = vblank;
      res.stat_irq = stat;
      res.line_rendered = rendered;
   end

endmodule

[sim/lcd_mode_timing_sequencer_top_tb.sv]
// Self-checking regression testbench for the LCD mode timing sequencer top level.
`timescale 1ns / 1ps

module lcd_mode_timing_sequencer_top_tb;

   // Cycles with no word accepted on either channel before the run is called hung.
   localparam int unsigned STALL_LIMIT = 4000;
   // Longest receiver hold-off used by the backpressure test.
   localparam int unsigned LONG_HOLD = 250;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [lmts_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [lmts_pkg::CSR_DATA_W-1:0] csr_wdata;

   lmts_req_if req ();
   lmts_rsp_if rsp ();

   lcd_mode_timing_sequencer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock: 10 ns period.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Timing predictor: its own copy of the scan-line state and the register settings.
   // ---------------------------------------------------------------------------------
   lmts_pkg::mode_type tm_mode;
   logic [7:0]  tm_line;
   int unsigned tm_acc;
   logic        tm_coin;
   logic        tm_vb_req;
   logic        tm_stat_req;

   logic        cfg_enable;
   logic [7:0]  cfg_compare;
   logic [3:0]  cfg_irq_en;

   // Status words still owed by the block, oldest first.
   lmts_pkg::result_type expected_status[$];

   int unsigned mismatch_count;
   int unsigned src_idle_pct;
   int unsigned sink_stall_pct;
   int unsigned hold_off_left;

   // Compare the line with the compare register; a hit raises stat when enabled.
   function automatic void compare_line();
      tm_coin = (tm_line == cfg_compare);
      if (tm_coin && cfg_irq_en[lmts_pkg::EN_COINCIDENCE])
         tm_stat_req = 1'b1;
   endfunction

   // Switch mode; entry into vblank always requests the vblank interrupt, and every
   // mode but pixel transfer requests stat when its own enable bit is set.
   function automatic void switch_mode(input lmts_pkg::mode_type next_mode);
      if (next_mode == tm_mode)
         return;
      tm_mode = next_mode;
      compare_line();
      if (next_mode == lmts_pkg::MODE_V_BLANK)
         tm_vb_req = 1'b1;
      if (next_mode != lmts_pkg::MODE_TRANSFER && cfg_irq_en[int'(next_mode)])
         tm_stat_req = 1'b1;
   endfunction

   // Advance the timing state by one word of elapsed cycles; at most one transition.
   function automatic lmts_pkg::result_type step_timing(input logic [7:0] cyc);
      lmts_pkg::result_type r;
      logic       rendered;
      rendered    = 1'b0;
      tm_vb_req   = 1'b0;
      tm_stat_req = 1'b0;
      if (cfg_enable) begin
         tm_acc = tm_acc + cyc;
         if (tm_acc > lmts_pkg::ACC_MAX)
            tm_acc = lmts_pkg::ACC_MAX;
         case (tm_mode)
            lmts_pkg::MODE_H_BLANK: begin
               if (tm_acc >= lmts_pkg::HBLANK_LEN) begin
                  tm_acc  = tm_acc - lmts_pkg::HBLANK_LEN;
                  tm_line = tm_line + 8'd1;
                  if (tm_line == lmts_pkg::VISIBLE_LINES)
                     switch_mode(lmts_pkg::MODE_V_BLANK);
                  else
                     switch_mode(lmts_pkg::MODE_OBJ_SCAN);
               end
            end
            lmts_pkg::MODE_V_BLANK: begin
               if (tm_acc >= lmts_pkg::VBLANK_LINE_LEN) begin
                  tm_acc = tm_acc - lmts_pkg::VBLANK_LINE_LEN;
                  if (tm_line >= lmts_pkg::LAST_LINE) begin
                     tm_line = '0;
                     switch_mode(lmts_pkg::MODE_OBJ_SCAN);
                  end else begin
                     tm_line = tm_line + 8'd1;
                  end
                  compare_line();
               end
            end
            lmts_pkg::MODE_OBJ_SCAN: begin
               if (tm_acc >= lmts_pkg::OAM_SCAN_LEN) begin
                  tm_acc = tm_acc - lmts_pkg::OAM_SCAN_LEN;
                  switch_mode(lmts_pkg::MODE_TRANSFER);
               end
            end
            default: begin
               if (tm_acc >= lmts_pkg::TRANSFER_LEN) begin
                  tm_acc = tm_acc - lmts_pkg::TRANSFER_LEN;
                  compare_line();
                  rendered = 1'b1;
                  switch_mode(lmts_pkg::MODE_H_BLANK);
               end
            end
         endcase
      end
      r.mode          = tm_mode;
      r.line          = tm_line;
      r.coincidence   = tm_coin;
      r.vblank_irq    = tm_vb_req;
      r.stat_irq      = tm_stat_req;
      r.line_rendered = rendered;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // Mismatch reporting and result checking.
   // ---------------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("%0t ns: MISMATCH %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int exp_v, input int got_v,
                              input logic [7:0] at_line);
      if (exp_v != got_v)
         report_mismatch($sformatf("%s: expected %0d, got %0d (expected line %0d)",
                                   name, exp_v, got_v, at_line));
   endtask

   // Sample every accepted status word at the rising edge and compare it with the
   // oldest prediction.
   always @(posedge clock) begin
      lmts_pkg::result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_status.size() == 0) begin
            report_mismatch("status word with no prediction pending");
         end else begin
            want = expected_status.pop_front();
            check_field("mode", want.mode, rsp.mode, want.line);
            check_field("line", want.line, rsp.line, want.line);
            check_field("coincidence", want.coincidence, rsp.coincidence, want.line);
            check_field("vblank_irq", want.vblank_irq, rsp.vblank_irq, want.line);
            check_field("stat_irq", want.stat_irq, rsp.stat_irq, want.line);
            check_field("line_rendered", want.line_rendered, rsp.line_rendered,
                        want.line);
         end
      end
   end

   // Receiver: honor a long hold-off when one is requested, else stall at random.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp.ready <= 1'b0;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // Watchdog: count cycles in which neither channel moves a word.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("lcd_mode_timing_sequencer_top regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------------

   // Offer one word, idling first at random, and predict it once it is taken.
   task automatic send_word(input logic [7:0] cyc);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid          <= 1'b1;
      req.elapsed_cycles <= cyc;
      @(posedge clock);
      while (!req.ready)
         @(posedge clock);
      expected_status.push_back(step_timing(cyc));
   endtask

   // Drop valid, wait for every owed status word, then allow the pipeline to settle.
   task automatic drain_block();
      @(negedge clock);
      req.valid <= 1'b0;
      while (expected_status.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [lmts_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [7:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         lmts_pkg::CSR_DISPLAY_ENABLE:   cfg_enable  = val[0];
         lmts_pkg::CSR_LINE_COMPARE:     cfg_compare = val;
         lmts_pkg::CSR_STAT_IRQ_ENABLES: cfg_irq_en  = val[3:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic enable, input logic [7:0] compare,
                             input logic [3:0] irq_en);
      drain_block();
      write_csr(lmts_pkg::CSR_DISPLAY_ENABLE, {7'd0, enable});
      write_csr(lmts_pkg::CSR_LINE_COMPARE, compare);
      write_csr(lmts_pkg::CSR_STAT_IRQ_ENABLES, {4'd0, irq_en});
   endtask

   // Mostly uniform cycle counts, with weight on large batches (to cross modes and
   // fill the accumulator) and on small ones (to sit inside a mode).
   function automatic logic [7:0] pick_cycles();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 55)
         return 8'($urandom_range(255));
      else if (sel < 75)
         return 8'($urandom_range(255, 180));
      else if (sel < 92)
         return 8'($urandom_range(20));
      else if (sel < 96)
         return 8'd0;
      return 8'hFF;
   endfunction

   task automatic send_random(input int unsigned count);
      repeat (count) send_word(pick_cycles());
   endtask

   // ---------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------

   // Zero and full-scale batches from reset: a step with no transition, the whole
   // visible-line cycle, and accumulator saturation under a run of full batches.
   task automatic test_edge_values();
      logic [7:0] seq[18];
      seq = '{8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
              8'd255, 8'd1, 8'd0, 8'd80, 8'd172, 8'd204, 8'd3, 8'd255, 8'd128};
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      set_config(1'b1, 8'd1, 4'hF);
      foreach (seq[i])
         send_word(seq[i]);
   endtask

   // Display off: state must hold and no request or pulse may appear.
   task automatic test_display_freeze();
      set_config(1'b0, 8'd1, 4'hF);
      send_word(8'd255);
      send_word(8'd0);
      send_word(8'd200);
      send_word(8'd255);
      set_config(1'b1, 8'd1, 4'hF);
   endtask

   task automatic test_steady_stream();
      set_config(1'b1, 8'd0, 4'hF);
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      send_random(400);
   endtask

   task automatic test_sender_gaps();
      set_config(1'b1, lmts_pkg::VISIBLE_LINES, 4'b0011);
      src_idle_pct   = 68;
      sink_stall_pct = 0;
      send_random(300);
   endtask

   task automatic test_receiver_stalls();
      set_config(1'b1, lmts_pkg::LAST_LINE, 4'b1100);
      src_idle_pct   = 0;
      sink_stall_pct = 68;
      send_random(300);
   endtask

   // Both sides idle; halfway through, pause the sender until everything is back.
   task automatic test_both_idle();
      set_config(1'b1, 8'd255, 4'h0);
      src_idle_pct   = 21;
      sink_stall_pct = 21;
      send_random(120);
      drain_block();
      send_random(120);
   endtask

   // Hold the receiver off for a long stretch while the sender keeps offering, so the
   // block fills and drops ready.
   task automatic test_backpressure();
      set_config(1'b1, 8'($urandom_range(lmts_pkg::VISIBLE_LINES - 1)), 4'hF);
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      @(posedge clock);
      hold_off_left = LONG_HOLD;
      send_random(80);
   endtask

   // Several random settings, some with the display switched off for a while.
   task automatic test_random_settings();
      repeat (6) begin
         set_config(($urandom_range(3) != 0), 8'($urandom_range(lmts_pkg::LAST_LINE)),
                    4'($urandom_range(15)));
         src_idle_pct   = $urandom_range(1) ? 21 : 0;
         sink_stall_pct = $urandom_range(1) ? 21 : 0;
         send_random(35);
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = lmts_pkg::CSR_DISPLAY_ENABLE;
      csr_wdata          = '0;
      req.valid          = 1'b0;
      req.elapsed_cycles = '0;
      rsp.ready          = 1'b0;
      src_idle_pct       = 0;
      sink_stall_pct     = 0;
      hold_off_left      = 0;
      mismatch_count     = 0;

      // Predictor state and register settings as they come out of reset.
      tm_mode     = lmts_pkg::MODE_H_BLANK;
      tm_line     = '0;
      tm_acc      = 0;
      tm_coin     = 1'b1;
      tm_vb_req   = 1'b0;
      tm_stat_req = 1'b0;
      cfg_enable  = 1'b1;
      cfg_compare = '0;
      cfg_irq_en  = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_values();
      test_display_freeze();
      test_steady_stream();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_backpressure();
      test_random_settings();

      // Let the last status words come back, then a few more cycles for stragglers.
      drain_block();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0)
         $display("lcd_mode_timing_sequencer_top regression: pass");
      else
         $display("lcd_mode_timing_sequencer_top regression: fail");
      $finish;
   end

endmodule
